@@ sv/crt_pkg.sv @@
// Shared types and codes for the copy-on-write page reference-count table.
// No dependencies; imported by crt_cell, crt_ctrl and the top level.
package crt_pkg;

   localparam int ACTION_BITS = 3;
   localparam int STATUS_BITS = 3;

   localparam logic [ACTION_BITS-1:0] ACT_ALLOCATE = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_RELEASE  = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_SHARE    = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_FORK     = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_QUERY    = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NO_FRAME  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_ZERO_REFS = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_SATURATED = 3'd4;

   // Flags of the search token that walks down the row of cells.
   typedef struct packed {
      logic valid;
      logic found;
      logic free;
   } scan_flags_type;

   // Update of the entry that the request looked up.
   typedef struct packed {
      logic en;
      logic valid;
   } entry_write_type;

endpackage

@@ sv/crt_cell.sv @@
// One table slot: valid bit, frame number and reference count, plus one stage
// of the search token. Depends on crt_pkg.
module crt_cell #(
   parameter int ENTRY_INDEX = 0,
   parameter int IDX_BITS    = 6,
   parameter int FRAME_BITS  = 20,
   parameter int REF_BITS    = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  crt_pkg::scan_flags_type prev_scan,
   input  logic [IDX_BITS-1:0]     prev_hit_idx,
   input  logic [REF_BITS-1:0]     prev_hit_refs,
   input  logic [IDX_BITS-1:0]     prev_free_idx,
   output crt_pkg::scan_flags_type next_scan,
   output logic [IDX_BITS-1:0]     next_hit_idx,
   output logic [REF_BITS-1:0]     next_hit_refs,
   output logic [IDX_BITS-1:0]     next_free_idx,
   input  logic [FRAME_BITS-1:0]   key_frame,
   input  crt_pkg::entry_write_type wr_e,
   input  logic [IDX_BITS-1:0]     wr_e_idx,
   input  logic [REF_BITS-1:0]     wr_e_refs,
   input  logic                    wr_s_en,
   input  logic [IDX_BITS-1:0]     wr_s_idx,
   input  logic [FRAME_BITS-1:0]   wr_s_frame
);
   import crt_pkg::*;

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(ENTRY_INDEX);

   logic                  valid_ff, valid_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [REF_BITS-1:0]   refs_ff, refs_in;
   scan_flags_type        scan_ff, scan_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [REF_BITS-1:0]   hit_refs_ff, hit_refs_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  hit, take_hit, take_free, my_e, my_s;

   // The first matching and the first free slot win, so a cell only claims
   // the token when no earlier cell has done so.
   assign hit       = valid_ff && (frame_ff == key_frame);
   assign take_hit  = !prev_scan.found && hit;
   assign take_free = !prev_scan.free && !valid_ff;

   always_comb begin
      scan_in.valid = prev_scan.valid;
      scan_in.found = prev_scan.found || hit;
      scan_in.free  = prev_scan.free || !valid_ff;
      hit_idx_in    = take_hit ? MY_IDX : prev_hit_idx;
      hit_refs_in   = take_hit ? refs_ff : prev_hit_refs;
      free_idx_in   = take_free ? MY_IDX : prev_free_idx;
   end

   assign my_e = wr_e.en && (wr_e_idx == MY_IDX);
   assign my_s = wr_s_en && (wr_s_idx == MY_IDX);

   always_comb begin
      priority if (my_s) begin
         valid_in = 1'b1;
         frame_in = wr_s_frame;
         refs_in  = REF_BITS'(1);
      end else if (my_e) begin
         valid_in = wr_e.valid;
         frame_in = frame_ff;
         refs_in  = wr_e_refs;
      end else begin
         valid_in = valid_ff;
         frame_in = frame_ff;
         refs_in  = refs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         scan_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         scan_ff  <= scan_in;
      end
      frame_ff    <= frame_in;
      refs_ff     <= refs_in;
      hit_idx_ff  <= hit_idx_in;
      hit_refs_ff <= hit_refs_in;
      free_idx_ff <= free_idx_in;
   end

   assign next_scan     = scan_ff;
   assign next_hit_idx  = hit_idx_ff;
   assign next_hit_refs = hit_refs_ff;
   assign next_free_idx = free_idx_ff;

endmodule

@@ sv/crt_ctrl.sv @@
// Request control: holds the request, launches the search token, decides the
// action from what the token gathered and drives the slot updates and result.
// Depends on crt_pkg.
module crt_ctrl #(
   parameter int ENTRIES    = 64,
   parameter int FRAME_BITS = 20,
   parameter int REF_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [crt_pkg::ACTION_BITS-1:0]     req_action,
   input  logic [FRAME_BITS-1:0]               req_frame,
   input  logic [FRAME_BITS-1:0]               req_new_frame,
   input  logic                                req_new_frame_ok,
   output crt_pkg::scan_flags_type             head_scan,
   output logic [FRAME_BITS-1:0]               key_frame,
   input  crt_pkg::scan_flags_type             tail_scan,
   input  logic [$clog2(ENTRIES)-1:0]          tail_hit_idx,
   input  logic [REF_BITS-1:0]                 tail_hit_refs,
   input  logic [$clog2(ENTRIES)-1:0]          tail_free_idx,
   output crt_pkg::entry_write_type            wr_e,
   output logic [$clog2(ENTRIES)-1:0]          wr_e_idx,
   output logic [REF_BITS-1:0]                 wr_e_refs,
   output logic                                wr_s_en,
   output logic [$clog2(ENTRIES)-1:0]          wr_s_idx,
   output logic [FRAME_BITS-1:0]               wr_s_frame,
   output logic                                rsp_strobe,
   output logic [FRAME_BITS-1:0]               rsp_result_frame,
   output logic [REF_BITS-1:0]                 rsp_refs,
   output logic [crt_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic                                rsp_release_valid,
   output logic [FRAME_BITS-1:0]               rsp_release_frame,
   output logic                                rsp_copy_valid,
   output logic [FRAME_BITS-1:0]               rsp_copy_source,
   output logic [$clog2(ENTRIES+1)-1:0]        rsp_allocated
);
   import crt_pkg::*;

   localparam int UCNT_BITS = $clog2(ENTRIES + 1);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

   logic                   busy_ff, busy_in;
   logic                   launch_ff, launch_in;
   logic [ACTION_BITS-1:0] act_ff;
   logic [FRAME_BITS-1:0]  key_ff, nf_ff;
   logic                   ok_ff;
   logic [UCNT_BITS-1:0]   used_ff, used_in;
   logic                   rsp_strobe_ff;
   logic [FRAME_BITS-1:0]  res_frame_ff, res_frame_in;
   logic [REF_BITS-1:0]    res_refs_ff, res_refs_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic                   rel_v_ff, rel_v_in;
   logic [FRAME_BITS-1:0]  rel_f_ff, rel_f_in;
   logic                   cp_v_ff, cp_v_in;
   logic [FRAME_BITS-1:0]  cp_s_ff, cp_s_in;
   logic                   accept, done;
   logic [REF_BITS-1:0]    refs_dec, refs_inc;
   logic                   e_en, e_valid, s_en;
   logic [REF_BITS-1:0]    e_refs;

   assign accept    = start && !busy_ff;
   assign done      = tail_scan.valid;
   assign refs_dec  = tail_hit_refs - REF_BITS'(1);
   assign refs_inc  = tail_hit_refs + REF_BITS'(1);
   assign busy_in   = accept || (busy_ff && !done);
   assign launch_in = accept;

   // Decision on the gathered lookup; only used in the cycle the token leaves
   // the last cell.
   always_comb begin
      res_frame_in  = '0;
      res_refs_in   = '0;
      res_status_in = ST_OK;
      rel_v_in      = 1'b0;
      rel_f_in      = '0;
      cp_v_in       = 1'b0;
      cp_s_in       = '0;
      e_en          = 1'b0;
      e_valid       = 1'b1;
      e_refs        = tail_hit_refs;
      s_en          = 1'b0;
      used_in       = used_ff;
      unique case (act_ff)
         ACT_ALLOCATE: begin
            if (!ok_ff) begin
               res_status_in = ST_NO_FRAME;
            end else if (!tail_scan.free) begin
               res_status_in = ST_NO_FRAME;
               rel_v_in      = 1'b1;
               rel_f_in      = nf_ff;
            end else begin
               s_en         = 1'b1;
               res_frame_in = nf_ff;
               res_refs_in  = REF_BITS'(1);
               used_in      = used_ff + UCNT_BITS'(1);
            end
         end
         ACT_RELEASE: begin
            if (!tail_scan.found) begin
               res_status_in = ST_NOT_FOUND;
            end else if (tail_hit_refs == '0) begin
               res_status_in = ST_ZERO_REFS;
            end else begin
               e_en        = 1'b1;
               e_refs      = refs_dec;
               res_refs_in = refs_dec;
               if (refs_dec == '0) begin
                  // The last reference is gone: free the slot and hand the
                  // frame back to the allocator.
                  e_valid  = 1'b0;
                  rel_v_in = 1'b1;
                  rel_f_in = key_ff;
                  used_in  = used_ff - UCNT_BITS'(1);
               end
            end
         end
         ACT_SHARE: begin
            if (!tail_scan.found) begin
               res_status_in = ST_NOT_FOUND;
            end else if (tail_hit_refs == REF_MAX) begin
               res_status_in = ST_SATURATED;
               res_refs_in   = REF_MAX;
            end else begin
               e_en        = 1'b1;
               e_refs      = refs_inc;
               res_refs_in = refs_inc;
            end
         end
         ACT_FORK: begin
            if (!tail_scan.found) begin
               res_status_in = ST_NOT_FOUND;
            end else if (tail_hit_refs == '0) begin
               res_status_in = ST_ZERO_REFS;
            end else if (tail_hit_refs == REF_BITS'(1)) begin
               res_frame_in = key_ff;
               res_refs_in  = REF_BITS'(1);
            end else if (!ok_ff) begin
               res_status_in = ST_NO_FRAME;
               res_refs_in   = tail_hit_refs;
            end else if (!tail_scan.free) begin
               res_status_in = ST_NO_FRAME;
               res_refs_in   = tail_hit_refs;
               rel_v_in      = 1'b1;
               rel_f_in      = nf_ff;
            end else begin
               e_en         = 1'b1;
               e_refs       = refs_dec;
               s_en         = 1'b1;
               res_frame_in = nf_ff;
               res_refs_in  = REF_BITS'(1);
               cp_v_in      = 1'b1;
               cp_s_in      = key_ff;
               used_in      = used_ff + UCNT_BITS'(1);
            end
         end
         ACT_QUERY: begin
            if (!tail_scan.found) begin
               res_status_in = ST_NOT_FOUND;
            end else begin
               res_refs_in = tail_hit_refs;
            end
         end
         default: begin
            res_status_in = ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         launch_ff     <= 1'b0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         launch_ff     <= launch_in;
         rsp_strobe_ff <= done;
         if (done) begin
            used_ff <= used_in;
         end
      end
      if (accept) begin
         act_ff <= req_action;
         key_ff <= req_frame;
         nf_ff  <= req_new_frame;
         ok_ff  <= req_new_frame_ok;
      end
      if (done) begin
         res_frame_ff  <= res_frame_in;
         res_refs_ff   <= res_refs_in;
         res_status_ff <= res_status_in;
         rel_v_ff      <= rel_v_in;
         rel_f_ff      <= rel_f_in;
         cp_v_ff       <= cp_v_in;
         cp_s_ff       <= cp_s_in;
      end
   end

   always_comb begin
      head_scan.valid = launch_ff;
      head_scan.found = 1'b0;
      head_scan.free  = 1'b0;
   end

   assign busy      = busy_ff;
   assign key_frame = key_ff;

   assign wr_e.en    = done && e_en;
   assign wr_e.valid = e_valid;
   assign wr_e_idx   = tail_hit_idx;
   assign wr_e_refs  = e_refs;
   assign wr_s_en    = done && s_en;
   assign wr_s_idx   = tail_free_idx;
   assign wr_s_frame = nf_ff;

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_result_frame  = res_frame_ff;
   assign rsp_refs          = res_refs_ff;
   assign rsp_status        = res_status_ff;
   assign rsp_release_valid = rel_v_ff;
   assign rsp_release_frame = rel_f_ff;
   assign rsp_copy_valid    = cp_v_ff;
   assign rsp_copy_source   = cp_s_ff;
   assign rsp_allocated     = used_ff;

endmodule

@@ sv/cow_page_refcount_table_unit.sv @@
// Channel   Handshake          Ports
// request   start & !busy      req_action, req_frame, req_new_frame, req_new_frame_ok
// result    rsp_strobe (1 cyc) rsp_result_frame, rsp_refs, rsp_status, rsp_release_valid,
//                              rsp_release_frame, rsp_copy_valid, rsp_copy_source,
//                              rsp_allocated
//
// A new request is accepted from the result cycle on. The search token moves one
// slot cell per cycle down the row, and the result is registered when the token
// leaves the last cell.
// Reset is synchronous; all slots come out empty and the table is usable at once.
// The result is shown for one cycle and cannot be held off.
// Depends on crt_pkg, crt_cell and crt_ctrl.
module cow_page_refcount_table_unit #(
   parameter int ENTRIES    = 64,
   parameter int FRAME_BITS = 20,
   parameter int REF_BITS   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [crt_pkg::ACTION_BITS-1:0] req_action,
   input  logic [FRAME_BITS-1:0]           req_frame,
   input  logic [FRAME_BITS-1:0]           req_new_frame,
   input  logic                            req_new_frame_ok,
   output logic                            rsp_strobe,
   output logic [FRAME_BITS-1:0]           rsp_result_frame,
   output logic [REF_BITS-1:0]             rsp_refs,
   output logic [crt_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                            rsp_release_valid,
   output logic [FRAME_BITS-1:0]           rsp_release_frame,
   output logic                            rsp_copy_valid,
   output logic [FRAME_BITS-1:0]           rsp_copy_source,
   output logic [$clog2(ENTRIES+1)-1:0]    rsp_allocated
);
   import crt_pkg::*;

   localparam int IDX_BITS = $clog2(ENTRIES);

   scan_flags_type        scan_chain     [0:ENTRIES];
   logic [IDX_BITS-1:0]   hit_idx_chain  [0:ENTRIES];
   logic [REF_BITS-1:0]   hit_refs_chain [0:ENTRIES];
   logic [IDX_BITS-1:0]   free_idx_chain [0:ENTRIES];
   logic [FRAME_BITS-1:0] key_frame;
   entry_write_type       wr_e;
   logic [IDX_BITS-1:0]   wr_e_idx;
   logic [REF_BITS-1:0]   wr_e_refs;
   logic                  wr_s_en;
   logic [IDX_BITS-1:0]   wr_s_idx;
   logic [FRAME_BITS-1:0] wr_s_frame;

   assign hit_idx_chain[0]  = '0;
   assign hit_refs_chain[0] = '0;
   assign free_idx_chain[0] = '0;

   crt_ctrl #(
      .ENTRIES    (ENTRIES),
      .FRAME_BITS (FRAME_BITS),
      .REF_BITS   (REF_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_frame         (req_frame),
      .req_new_frame     (req_new_frame),
      .req_new_frame_ok  (req_new_frame_ok),
      .head_scan         (scan_chain[0]),
      .key_frame         (key_frame),
      .tail_scan         (scan_chain[ENTRIES]),
      .tail_hit_idx      (hit_idx_chain[ENTRIES]),
      .tail_hit_refs     (hit_refs_chain[ENTRIES]),
      .tail_free_idx     (free_idx_chain[ENTRIES]),
      .wr_e              (wr_e),
      .wr_e_idx          (wr_e_idx),
      .wr_e_refs         (wr_e_refs),
      .wr_s_en           (wr_s_en),
      .wr_s_idx          (wr_s_idx),
      .wr_s_frame        (wr_s_frame),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_frame  (rsp_result_frame),
      .rsp_refs          (rsp_refs),
      .rsp_status        (rsp_status),
      .rsp_release_valid (rsp_release_valid),
      .rsp_release_frame (rsp_release_frame),
      .rsp_copy_valid    (rsp_copy_valid),
      .rsp_copy_source   (rsp_copy_source),
      .rsp_allocated     (rsp_allocated)
   );

   genvar i;
   generate
      for (i = 0; i < ENTRIES; i++) begin : g_cell
         crt_cell #(
            .ENTRY_INDEX (i),
            .IDX_BITS    (IDX_BITS),
            .FRAME_BITS  (FRAME_BITS),
            .REF_BITS    (REF_BITS)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .prev_scan     (scan_chain[i]),
            .prev_hit_idx  (hit_idx_chain[i]),
            .prev_hit_refs (hit_refs_chain[i]),
            .prev_free_idx (free_idx_chain[i]),
            .next_scan     (scan_chain[i+1]),
            .next_hit_idx  (hit_idx_chain[i+1]),
            .next_hit_refs (hit_refs_chain[i+1]),
            .next_free_idx (free_idx_chain[i+1]),
            .key_frame     (key_frame),
            .wr_e          (wr_e),
            .wr_e_idx      (wr_e_idx),
            .wr_e_refs     (wr_e_refs),
            .wr_s_en       (wr_s_en),
            .wr_s_idx      (wr_s_idx),
            .wr_s_frame    (wr_s_frame)
         );
      end
   endgenerate

   // An accepted request keeps the block busy while its token is in flight.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy afterwards");

   // Results never come in consecutive cycles.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   // A copy request only comes with a successful fork and no frame return.
   a_copy_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_copy_valid) |-> (rsp_status == ST_OK && !rsp_release_valid))
      else $error("copy request with failure status or frame release");

   // The slot and entry updates are issued only while the token leaves the row.
   a_write_on_done: assert property (@(posedge clock) disable iff (reset)
      (wr_e.en || wr_s_en) |-> (scan_chain[ENTRIES].valid && busy))
      else $error("table update outside the end of a search");

endmodule
